// ===== hw/rtl/shrd_pkg.sv =====
// Shared types and constants for the sample history ring with decimated dump.
// Used by shrd_div and by the top level; no dependencies of its own.
package shrd_pkg;

    // Width of counts, point numbers and record indexes.
    localparam int CNT_W = 7;

    // One stored record: time, temperature, humidity, pressure, valve.
    localparam int TIME_W  = 32;
    localparam int TEMP_W  = 16;
    localparam int HUM_W   = 14;
    localparam int PRES_W  = 17;
    localparam int VALVE_W = 7;
    localparam int REC_W   = TIME_W + TEMP_W + HUM_W + PRES_W + VALVE_W;

    // Stream data widths, padded to whole bytes.
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 104;
    localparam int OUT_PAD_W  = OUT_DATA_W - REC_W - 2 * CNT_W;

    // Position of max_points within the input data word.
    localparam int MAXP_LSB = REC_W;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_RD   = 4'b0100,
        ST_LOAD = 4'b1000
    } state_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] quotient;
        logic [CNT_W-1:0] remainder;
    } div_rsp_t;

    function automatic logic [OUT_DATA_W-1:0] pack_result(
        input logic [REC_W-1:0] rec,
        input logic [CNT_W-1:0] points,
        input logic [CNT_W-1:0] stored
    );
        return {{OUT_PAD_W{1'b0}}, stored, points, rec};
    endfunction

endpackage

// ===== hw/rtl/shrd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module shrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/shrd_div.sv =====
// Restoring divider, one quotient bit per cycle, for the readout step size.
// Depends on shrd_pkg for widths and the request and response structs.
module shrd_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  shrd_pkg::div_req_t  req,
    output shrd_pkg::div_rsp_t  rsp
);

    localparam int W     = shrd_pkg::CNT_W;
    localparam int STEPW = $clog2(W);

    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dsr_reg, dsr_next;
    logic [STEPW-1:0] step_reg, step_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       fits;

    always_comb begin
        trial = {rem_reg, quo_reg[W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[W-2:0], fits};
            rem_next  = fits ? diff[W-1:0] : trial[W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEPW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== hw/rtl/sample_history_ring_decimated_dump.sv =====
// Sample history ring with decimated readout: top level over shrd_pkg, shrd_ram and shrd_div.
// Add, clear, ignored items and reads of an empty store: one result in the cycle after acceptance.
// Read of n points: seven divider steps, a handover step, a RAM read and the output register
// put out the first record, then one per cycle while m_tready holds; the divider is skipped
// when one record is returned.
// Reset (synchronous, aresetn low) empties the ring; record RAM contents are not cleared.
module sample_history_ring_decimated_dump #(
    parameter int DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // From bit 0: sample_time, sample_temperature, sample_humidity, sample_pressure,
    // sample_valve, max_points, zero padding.
    input  logic [shrd_pkg::IN_DATA_W-1:0]    s_tdata,
    // action
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // From bit 0: point_time, point_temperature, point_humidity, point_pressure,
    // point_valve, points_in_reply, stored_count, zero padding.
    output logic [shrd_pkg::OUT_DATA_W-1:0]   m_tdata,
    // point_valid
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = shrd_pkg::CNT_W;

    shrd_pkg::state_t state_reg, state_next;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW:0]   den2_reg, den2_next;
    logic [AW-1:0] start_reg, start_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] q_reg, q_next;
    logic [CW:0]   r_reg, r_next;

    logic                            m_tvalid_reg, m_tvalid_next;
    logic [shrd_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                            m_tuser_reg, m_tuser_next;
    logic                            m_tlast_reg, m_tlast_next;

    logic                          out_free;
    logic                          s_accept;
    logic [CW-1:0]                 maxp;
    logic [CW-1:0]                 n_req;
    logic                          full;
    logic [CW:0]                   r_sum;
    logic                          carry;
    logic [CW:0]                   r_step;
    logic [CW-1:0]                 q_step;
    logic [CW-1:0]                 idx_sel;
    logic [AW:0]                   addr_sum;
    logic [AW-1:0]                 raddr;
    logic                          ram_we;
    logic                          ram_re;
    logic [shrd_pkg::REC_W-1:0]    ram_rdata;
    logic                          last_point;
    shrd_pkg::div_req_t            div_req;
    shrd_pkg::div_rsp_t            div_rsp;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == shrd_pkg::ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    assign maxp  = s_tdata[shrd_pkg::MAXP_LSB +: CW];
    assign full  = (count_reg == CW'(DEPTH));
    assign n_req = (maxp != '0 && maxp < count_reg) ? maxp : count_reg;

    // Index of point i+1 from that of point i: add the whole and fractional step,
    // carrying one when the running sum plus the doubled remainder reaches twice the divisor.
    assign r_sum  = r_reg + {div_rsp.remainder, 1'b0};
    assign carry  = (r_sum >= den2_reg);
    assign r_step = carry ? (r_sum - den2_reg) : r_sum;
    assign q_step = q_reg + div_rsp.quotient + CW'(carry);

    assign idx_sel  = (state_reg == shrd_pkg::ST_LOAD) ? q_step : q_reg;
    assign addr_sum = {1'b0, start_reg} + {1'b0, idx_sel[AW-1:0]};
    assign raddr    = (addr_sum >= (AW+1)'(DEPTH)) ? AW'(addr_sum - (AW+1)'(DEPTH))
                                                   : addr_sum[AW-1:0];

    assign last_point = ((i_reg + 1'b1) == n_reg);

    assign ram_we = s_accept && (shrd_pkg::action_t'(s_tuser) == shrd_pkg::ACT_ADD);

    always_comb begin
        div_req.start    = s_accept && (shrd_pkg::action_t'(s_tuser) == shrd_pkg::ACT_READ)
                           && (count_reg != '0) && (n_req != CW'(1));
        div_req.dividend = count_reg - 1'b1;
        div_req.divisor  = n_req - 1'b1;
    end

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        den2_next     = den2_reg;
        start_next    = start_reg;
        i_next        = i_reg;
        q_next        = q_reg;
        r_next        = r_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        ram_re        = 1'b0;

        unique case (state_reg)
            shrd_pkg::ST_IDLE: begin
                if (s_accept) begin
                    m_tuser_next = 1'b0;
                    m_tlast_next = 1'b1;
                    unique case (shrd_pkg::action_t'(s_tuser))
                        shrd_pkg::ACT_ADD: begin
                            head_next  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                            count_next = full ? count_reg : count_reg + 1'b1;
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = shrd_pkg::pack_result('0, '0, count_next);
                        end
                        shrd_pkg::ACT_CLEAR: begin
                            head_next  = '0;
                            count_next = '0;
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = shrd_pkg::pack_result('0, '0, '0);
                        end
                        shrd_pkg::ACT_READ: begin
                            if (count_reg == '0) begin
                                m_tvalid_next = 1'b1;
                                m_tdata_next  = shrd_pkg::pack_result('0, '0, count_reg);
                            end else begin
                                n_next     = n_req;
                                den2_next  = {n_req - 1'b1, 1'b0};
                                start_next = full ? head_reg : '0;
                                i_next     = '0;
                                q_next     = '0;
                                r_next     = {1'b0, n_req - 1'b1};
                                state_next = (n_req == CW'(1)) ? shrd_pkg::ST_RD
                                                               : shrd_pkg::ST_DIV;
                            end
                        end
                        default: begin
                            m_tvalid_next = 1'b1;
                            m_tdata_next  = shrd_pkg::pack_result('0, '0, count_reg);
                        end
                    endcase
                end
            end
            shrd_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = shrd_pkg::ST_RD;
                end
            end
            shrd_pkg::ST_RD: begin
                ram_re     = 1'b1;
                state_next = shrd_pkg::ST_LOAD;
            end
            shrd_pkg::ST_LOAD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = last_point;
                    m_tdata_next  = shrd_pkg::pack_result(ram_rdata, n_reg, count_reg);
                    if (last_point) begin
                        state_next = shrd_pkg::ST_IDLE;
                    end else begin
                        // Fetch the next point while this one is handed over.
                        ram_re = 1'b1;
                        i_next = i_reg + 1'b1;
                        q_next = q_step;
                        r_next = r_step;
                    end
                end
            end
            default: begin
                state_next = shrd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= shrd_pkg::ST_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        n_reg       <= n_next;
        den2_reg    <= den2_next;
        start_reg   <= start_next;
        i_reg       <= i_next;
        q_reg       <= q_next;
        r_reg       <= r_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    shrd_ram #(
        .WIDTH (shrd_pkg::REC_W),
        .DEPTH (DEPTH)
    ) u_rec_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata (s_tdata[shrd_pkg::REC_W-1:0]),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    shrd_div u_step_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== test/sample_history_ring_decimated_dump_tb.sv =====
// Self-checking testbench for sample_history_ring_decimated_dump: adds, reads, clears
// and ignored codes over a stream handshake, with a predicting scoreboard and random stalls.
// Depends on shrd_pkg and the top level of the block.
`timescale 1ns / 1ps

module sample_history_ring_decimated_dump_tb;
    import shrd_pkg::*;

    localparam int DEPTH = 64;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int LATENCY_CYCLES = 20;
    localparam int RANDOM_ITEMS = 270;
    localparam int CALM_FROM = 240;
    localparam int PAUSE_AT = 150;
    localparam int CLEAR_UNTIL = 80;

    typedef struct {
        logic [TIME_W-1:0]  ptime;
        logic [TEMP_W-1:0]  ptemp;
        logic [HUM_W-1:0]   phum;
        logic [PRES_W-1:0]  ppres;
        logic [VALVE_W-1:0] pvalve;
        logic               valid;
        logic [CNT_W-1:0]   points;
        logic [CNT_W-1:0]   stored;
        logic               last;
    } history_point_t;

    class history_scoreboard;
        logic [TIME_W-1:0]  time_mem[DEPTH];
        logic [TEMP_W-1:0]  temp_mem[DEPTH];
        logic [HUM_W-1:0]   hum_mem[DEPTH];
        logic [PRES_W-1:0]  pres_mem[DEPTH];
        logic [VALVE_W-1:0] valve_mem[DEPTH];
        int unsigned        head;
        int unsigned        count;
        history_point_t     pending_points[$];
        int                 mismatches;

        function new();
            head = 0;
            count = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_points.size();
        endfunction

        function void push_ack();
            history_point_t p;
            p = '{default: '0};
            p.stored = count[CNT_W-1:0];
            p.last = 1'b1;
            pending_points.push_back(p);
        endfunction

        // Works out the results that one accepted input transaction causes.
        function void note_input(logic [1:0] act, logic [IN_DATA_W-1:0] data);
            int unsigned maxp;
            int unsigned npts;
            int unsigned first;
            int unsigned idx;
            int unsigned den;
            int unsigned slot;
            history_point_t p;
            maxp = data[MAXP_LSB +: CNT_W];
            case (act)
                ACT_ADD: begin
                    time_mem[head]  = data[0 +: TIME_W];
                    temp_mem[head]  = data[TIME_W +: TEMP_W];
                    hum_mem[head]   = data[TIME_W + TEMP_W +: HUM_W];
                    pres_mem[head]  = data[TIME_W + TEMP_W + HUM_W +: PRES_W];
                    valve_mem[head] = data[TIME_W + TEMP_W + HUM_W + PRES_W +: VALVE_W];
                    head = (head + 1) % DEPTH;
                    if (count < DEPTH) count++;
                    push_ack();
                end
                ACT_CLEAR: begin
                    head = 0;
                    count = 0;
                    push_ack();
                end
                ACT_READ: begin
                    if (count == 0) begin
                        push_ack();
                    end else begin
                        // When full, the oldest record sits where the next write goes.
                        first = (count < DEPTH) ? 0 : head;
                        npts = (maxp > 0 && maxp < count) ? maxp : count;
                        for (int unsigned i = 0; i < npts; i++) begin
                            if (count > npts) begin
                                if (npts == 1) begin
                                    idx = 0;
                                end else begin
                                    den = npts - 1;
                                    idx = (2 * i * (count - 1) + den) / (2 * den);
                                end
                            end else begin
                                idx = i;
                            end
                            if (idx >= count) idx = count - 1;
                            slot = (first + idx) % DEPTH;
                            p.ptime  = time_mem[slot];
                            p.ptemp  = temp_mem[slot];
                            p.phum   = hum_mem[slot];
                            p.ppres  = pres_mem[slot];
                            p.pvalve = valve_mem[slot];
                            p.valid  = 1'b1;
                            p.points = npts[CNT_W-1:0];
                            p.stored = count[CNT_W-1:0];
                            p.last   = (i + 1 == npts);
                            pending_points.push_back(p);
                        end
                    end
                end
                default: push_ack();
            endcase
        endfunction

        function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                if (mismatches < 10)
                    $display("%0t: mismatch on %s: expected %0h, actual %0h",
                             $realtime, name, want, got);
                return 0;
            end
            return 1;
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic valid, logic last);
            history_point_t p;
            bit ok;
            if (pending_points.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: result transaction with no expectation pending", $realtime);
                mismatches++;
                return;
            end
            p = pending_points.pop_front();
            ok = 1;
            ok &= field_ok("point_time", p.ptime, data[0 +: TIME_W]);
            ok &= field_ok("point_temperature", p.ptemp, data[TIME_W +: TEMP_W]);
            ok &= field_ok("point_humidity", p.phum, data[TIME_W + TEMP_W +: HUM_W]);
            ok &= field_ok("point_pressure", p.ppres,
                           data[TIME_W + TEMP_W + HUM_W +: PRES_W]);
            ok &= field_ok("point_valve", p.pvalve,
                           data[TIME_W + TEMP_W + HUM_W + PRES_W +: VALVE_W]);
            ok &= field_ok("point_valid", p.valid, valid);
            ok &= field_ok("points_in_reply", p.points, data[REC_W +: CNT_W]);
            ok &= field_ok("stored_count", p.stored, data[REC_W + CNT_W +: CNT_W]);
            ok &= field_ok("last", p.last, last);
            ok &= field_ok("padding", '0, data[OUT_DATA_W-1 -: OUT_PAD_W]);
            if (!ok) mismatches++;
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    history_scoreboard sb = new();
    bit calm = 0;

    sample_history_ring_decimated_dump #(.DEPTH(DEPTH)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic logic [IN_DATA_W-1:0] pack_sample(
        logic [TIME_W-1:0] t, logic [TEMP_W-1:0] temp, logic [HUM_W-1:0] hum,
        logic [PRES_W-1:0] pres, logic [VALVE_W-1:0] valve, logic [CNT_W-1:0] maxp
    );
        return {{(IN_DATA_W - REC_W - CNT_W){1'b0}}, maxp, valve, pres, hum, temp, t};
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_sample(logic [CNT_W-1:0] maxp);
        return pack_sample(TIME_W'($urandom), TEMP_W'($urandom_range(0, 65535)),
                           HUM_W'($urandom_range(0, 10000)),
                           PRES_W'($urandom_range(0, 131071)),
                           VALVE_W'($urandom_range(0, 100)), maxp);
    endfunction

    function automatic logic [CNT_W-1:0] random_points();
        int unsigned r;
        r = $urandom_range(0, 3);
        if (r == 0) return '0;
        if (r == 1) return CNT_W'($urandom_range(1, 3));
        return CNT_W'($urandom_range(0, 64));
    endfunction

    task automatic send_item(logic [1:0] act, logic [IN_DATA_W-1:0] data);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = data;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(act, data);
    endtask

    task automatic hold_off(int unsigned cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 9));
    endtask

    task automatic drain_results();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Receiver: bursts of back-pressure, none once the run has gone calm.
    initial begin
        int unsigned hold;
        hold = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (calm) begin
                m_tready = 1'b1;
            end else if (hold == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    // The stall holds until the count left runs out.
                    m_tready = 1'b0;
                    hold = $urandom_range(0, 8);
                end else begin
                    m_tready = 1'b1;
                    hold = $urandom_range(1, 24);
                end
            end else begin
                hold--;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int unsigned r;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_ADD;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part: empty store, ignored code, field extremes, point-count corners.
        send_item(ACT_READ, pack_sample('0, '0, '0, '0, '0, 7'd0));
        send_item(ACT_CLEAR, '0);
        send_item(ACT_UNUSED, '0);
        send_item(ACT_ADD, pack_sample('0, 16'h8000, 14'd0, 17'd0, 7'd0, 7'd0));
        send_item(ACT_ADD, pack_sample('1, 16'h7FFF, 14'd10000, 17'h1FFFF, 7'd100, 7'd64));
        send_item(ACT_READ, pack_sample('0, '0, '0, '0, '0, 7'd1));
        send_item(ACT_READ, pack_sample('0, '0, '0, '0, '0, 7'd0));
        hold_off(3);
        repeat (3) send_item(ACT_ADD, random_sample(random_points()));
        send_item(ACT_READ, pack_sample('0, '0, '0, '0, '0, 7'd2));
        send_item(ACT_READ, pack_sample('0, '0, '0, '0, '0, 7'd3));
        send_item(ACT_READ, pack_sample('0, '0, '0, '0, '0, 7'd5));
        send_item(ACT_READ, pack_sample('0, '0, '0, '0, '0, 7'd64));
        send_item(ACT_UNUSED, random_sample(7'd64));
        send_item(ACT_CLEAR, random_sample(7'd7));
        send_item(ACT_READ, random_sample(7'd4));
        hold_off(1);
        drain_results();

        // Random part: clears only early on, so the ring later fills and wraps.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == CALM_FROM) calm = 1;
            if (i == PAUSE_AT) begin
                hold_off(1);
                drain_results();
            end
            maybe_gap();
            r = $urandom_range(0, 99);
            if (r < 60)
                send_item(ACT_ADD, random_sample(random_points()));
            else if (r < 90)
                send_item(ACT_READ, random_sample(random_points()));
            else if (r < 95 && i < CLEAR_UNTIL)
                send_item(ACT_CLEAR, random_sample(random_points()));
            else if (r >= 95)
                send_item(ACT_UNUSED, random_sample(random_points()));
            else
                send_item(ACT_READ, random_sample(7'd1));
        end
        hold_off(1);

        drain_results();
        repeat (LATENCY_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
